// ===== rtl/centered_moving_average_7_unit_assert.svh =====
`ifndef CENTERED_MOVING_AVERAGE_7_UNIT_ASSERT_SVH
`define CENTERED_MOVING_AVERAGE_7_UNIT_ASSERT_SVH

// cond must imply expr at the same clock edge
`define CMA_ASSERT_NOW(label, clk, rst, cond, expr) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (expr)) \
      else $error("cma check failed");

// cond must imply expr at the following clock edge
`define CMA_ASSERT_NEXT(label, clk, rst, cond, expr) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (expr)) \
      else $error("cma check failed");

`endif

// ===== rtl/cma_pkg.sv =====
package cma_pkg;

   // window and number format
   localparam int HALF_WIDTH  = 3;
   localparam int SAMPLE_BITS = 32;
   localparam int FRAC_BITS   = 8;
   localparam int WIN_LEN     = 2 * HALF_WIDTH + 1;

   // port field widths
   localparam int IN_W  = 32;
   localparam int OUT_W = 40;

   // counters over the window
   localparam int CNT_W = $clog2(WIN_LEN + 1);
   localparam int TOP_W = $clog2(WIN_LEN);
   localparam int D_W   = $clog2(HALF_WIDTH + 1);

   // window sum and divider sizing
   localparam int SUM_W      = SAMPLE_BITS + $clog2(WIN_LEN);
   localparam int DIV_STEP   = 8;
   localparam int DIV_STAGES = (SUM_W + FRAC_BITS + DIV_STEP - 1) / DIV_STEP;
   localparam int DIV_LEN    = DIV_STAGES * DIV_STEP;
   localparam int Q_W        = (DIV_LEN + 1 > OUT_W + 1) ? DIV_LEN + 1 : OUT_W + 1;

   // saturation limits
   localparam logic [Q_W-1:0] Q_OUT_MAX = (Q_W'(1) << (OUT_W - 1)) - Q_W'(1);
   localparam logic signed [OUT_W-1:0] OUT_MAX = {1'b0, {(OUT_W - 1){1'b1}}};
   localparam logic signed [OUT_W-1:0] OUT_MIN = {1'b1, {(OUT_W - 1){1'b0}}};

   typedef logic signed [SAMPLE_BITS-1:0] sample_type;

   typedef enum logic {
      ST_STREAM,
      ST_FLUSH
   } front_state_type;

   // one averaging job: window sum and sample count
   typedef struct packed {
      logic                    valid;
      logic signed [SUM_W-1:0] sum;
      logic [CNT_W-1:0]        cnt;
      logic                    done;
   } job_type;

   // divider pipeline word: remainder and dividend/quotient shift register
   typedef struct packed {
      logic               valid;
      logic               neg;
      logic [CNT_W-1:0]   cnt;
      logic [CNT_W-1:0]   rem;
      logic [DIV_LEN-1:0] quo;
      logic               done;
   } div_type;

endpackage

// ===== rtl/cma_cell.sv =====
module cma_cell (
   input  logic                clock,
   input  logic                reset,
   input  logic                shift,
   input  cma_pkg::sample_type feed,
   output cma_pkg::sample_type held
);
   import cma_pkg::*;

   sample_type value_ff;

   // one tap of the sample line, takes its neighbor's sample on shift
   always_ff @(posedge clock) begin
      if (reset) begin
         value_ff <= '0;
      end else if (shift) begin
         value_ff <= feed;
      end
   end

   assign held = value_ff;

endmodule

// ===== rtl/cma_front.sv =====
module cma_front (
   input  logic                clock,
   input  logic                reset,
   input  logic                word_valid,
   output logic                word_ready,
   input  cma_pkg::sample_type word_sample,
   input  logic                word_last,
   input  logic                job_load,
   output cma_pkg::job_type    job
);
   import cma_pkg::*;

   sample_type              cell_q [WIN_LEN];
   front_state_type         state_ff, state_in;
   logic [CNT_W-1:0]        seen_ff, seen_in;
   logic signed [SUM_W-1:0] sum_ff, sum_in;
   logic [TOP_W-1:0]        top_ff, top_in;
   logic [D_W-1:0]          left_ff, left_in;
   job_type                 job_ff, job_in;

   logic                    take;
   logic [CNT_W-1:0]        fill;
   logic [CNT_W-1:0]        fill_m1;
   logic [CNT_W-1:0]        d_first;
   logic [CNT_W-1:0]        reach;
   logic signed [SUM_W-1:0] base;
   logic signed [SUM_W-1:0] drop;
   logic signed [SUM_W-1:0] win_sum;
   logic signed [SUM_W-1:0] trim;
   logic [TOP_W-1:0]        step_top;
   logic                    shrink;

   assign word_ready = job_load && (state_ff == ST_STREAM);
   assign take       = word_valid && word_ready;

   // sample line, newest in cell 0
   genvar g;
   generate
      for (g = 0; g < WIN_LEN; g++) begin : g_cell
         if (g == 0) begin : g_head
            cma_cell u_cell (
               .clock (clock),
               .reset (reset),
               .shift (take),
               .feed  (word_sample),
               .held  (cell_q[g])
            );
         end else begin : g_body
            cma_cell u_cell (
               .clock (clock),
               .reset (reset),
               .shift (take),
               .feed  (cell_q[g-1]),
               .held  (cell_q[g])
            );
         end
      end
   endgenerate

   // running sum of the frame's samples in the line
   assign fill    = (seen_ff == CNT_W'(WIN_LEN)) ? CNT_W'(WIN_LEN) : seen_ff + CNT_W'(1);
   assign fill_m1 = fill - CNT_W'(1);
   assign d_first = (fill_m1 < CNT_W'(HALF_WIDTH)) ? fill_m1 : CNT_W'(HALF_WIDTH);
   assign base    = (seen_ff == '0) ? '0 : sum_ff;
   assign drop    = (seen_ff == CNT_W'(WIN_LEN)) ? SUM_W'(cell_q[WIN_LEN-1]) : '0;
   assign win_sum = base + SUM_W'(word_sample) - drop;

   // flush: window end pulls in by one once it passes the center plus half width
   assign reach    = CNT_W'(left_ff) + CNT_W'(HALF_WIDTH);
   assign shrink   = reach < CNT_W'(top_ff);
   assign step_top = shrink ? TOP_W'(reach) : top_ff;
   assign trim     = shrink ? SUM_W'(cell_q[top_ff]) : '0;

   // next state and job
   always_comb begin
      state_in = state_ff;
      seen_in  = seen_ff;
      sum_in   = sum_ff;
      top_in   = top_ff;
      left_in  = left_ff;
      job_in   = '0;
      case (state_ff)
         ST_STREAM: begin
            if (take) begin
               sum_in      = win_sum;
               job_in.sum  = win_sum;
               job_in.cnt  = fill;
               if (!word_last) begin
                  seen_in      = fill;
                  job_in.valid = (seen_ff >= CNT_W'(HALF_WIDTH));
               end else begin
                  seen_in      = '0;
                  top_in       = TOP_W'(fill_m1);
                  left_in      = D_W'(d_first - CNT_W'(1));
                  job_in.valid = 1'b1;
                  job_in.done  = (d_first == '0);
                  if (d_first != '0) begin
                     state_in = ST_FLUSH;
                  end
               end
            end
         end
         ST_FLUSH: begin
            if (job_load) begin
               sum_in       = sum_ff - trim;
               top_in       = step_top;
               job_in.valid = 1'b1;
               job_in.sum   = sum_ff - trim;
               job_in.cnt   = CNT_W'(step_top) + CNT_W'(1);
               job_in.done  = (left_ff == '0);
               if (left_ff == '0) begin
                  state_in = ST_STREAM;
               end else begin
                  left_in = left_ff - D_W'(1);
               end
            end
         end
         default: begin
            state_in = ST_STREAM;
         end
      endcase
   end

   // state registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_STREAM;
         seen_ff  <= '0;
      end else begin
         state_ff <= state_in;
         seen_ff  <= seen_in;
      end
      sum_ff  <= sum_in;
      top_ff  <= top_in;
      left_ff <= left_in;
   end

   // job register toward the divider
   always_ff @(posedge clock) begin
      if (reset) begin
         job_ff.valid <= 1'b0;
      end else if (job_load) begin
         job_ff <= job_in;
      end
   end

   assign job = job_ff;

endmodule

// ===== rtl/cma_div_cell.sv =====
module cma_div_cell (
   input  logic             clock,
   input  logic             reset,
   input  logic             load,
   input  cma_pkg::div_type up,
   output cma_pkg::div_type down
);
   import cma_pkg::*;

   logic             valid_ff;
   div_type          data_ff, data_in;
   logic [CNT_W-1:0] rem;
   logic [DIV_LEN-1:0] quo;
   logic [CNT_W:0]   trial;

   // restoring division by the small count, DIV_STEP quotient bits per cell
   always_comb begin
      rem = up.rem;
      quo = up.quo;
      for (int j = 0; j < DIV_STEP; j++) begin
         trial = {rem, quo[DIV_LEN-1]};
         quo   = {quo[DIV_LEN-2:0], 1'b0};
         if (trial >= {1'b0, up.cnt}) begin
            rem    = CNT_W'(trial - {1'b0, up.cnt});
            quo[0] = 1'b1;
         end else begin
            rem = trial[CNT_W-1:0];
         end
      end
      data_in     = up;
      data_in.rem = rem;
      data_in.quo = quo;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (load) begin
         valid_ff <= up.valid;
      end
      if (load) begin
         data_ff <= data_in;
      end
   end

   always_comb begin
      down       = data_ff;
      down.valid = valid_ff;
   end

endmodule

// ===== rtl/centered_moving_average_7_unit.sv =====
// A result word passes the job register, the divider cells and the output register.
// Throughput: one sample word per cycle unless back-pressure stalls the divider; a frame's
//   last word blocks req_tready while the remaining flush averages enter the divider.
// The divider is a chain of 6 cells, each making 8 quotient bits per cycle unless stalled.
// Reset: synchronous, active high; clears all valid flags, the frame count and the line.
module centered_moving_average_7_unit (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_tvalid,
   output logic                      req_tready,
   input  logic [cma_pkg::IN_W-1:0]  req_tdata,   // [31:0] sample
   input  logic                      req_tlast,   // frame_end
   output logic                      rsp_tvalid,
   input  logic                      rsp_tready,
   output logic [cma_pkg::OUT_W-1:0] rsp_tdata,   // [39:0] average
   output logic                      rsp_tlast    // frame_done
);
   import cma_pkg::*;

   job_type                 job;
   div_type                 div_head;
   div_type                 div_q [DIV_STAGES];
   div_type                 tail;
   logic [SUM_W-1:0]        mag;
   logic [DIV_STAGES-1:0]   en_div;
   logic                    en_job;
   logic                    en_out;
   logic                    round_up;
   logic [Q_W-1:0]          q_mag;
   logic signed [OUT_W-1:0] avg_in;
   logic                    rsp_valid_ff;
   logic signed [OUT_W-1:0] avg_ff;
   logic                    last_ff;

   // load enables, from the output register back to the job register
   assign en_out = !rsp_valid_ff || rsp_tready;
   always_comb begin
      en_div[DIV_STAGES-1] = !div_q[DIV_STAGES-1].valid || en_out;
      for (int k = DIV_STAGES - 2; k >= 0; k--) begin
         en_div[k] = !div_q[k].valid || en_div[k+1];
      end
   end
   assign en_job = !job.valid || en_div[0];

   cma_front u_front (
      .clock       (clock),
      .reset       (reset),
      .word_valid  (req_tvalid),
      .word_ready  (req_tready),
      .word_sample (sample_type'(req_tdata[SAMPLE_BITS-1:0])),
      .word_last   (req_tlast),
      .job_load    (en_job),
      .job         (job)
   );

   // sign and magnitude, scaled by the fraction bits
   assign mag = job.sum[SUM_W-1] ? -job.sum : job.sum;
   always_comb begin
      div_head.valid = job.valid;
      div_head.neg   = job.sum[SUM_W-1];
      div_head.cnt   = job.cnt;
      div_head.rem   = '0;
      div_head.quo   = DIV_LEN'(mag) << FRAC_BITS;
      div_head.done  = job.done;
   end

   // divider chain
   genvar g;
   generate
      for (g = 0; g < DIV_STAGES; g++) begin : g_div
         if (g == 0) begin : g_head
            cma_div_cell u_div (
               .clock (clock),
               .reset (reset),
               .load  (en_div[g]),
               .up    (div_head),
               .down  (div_q[g])
            );
         end else begin : g_body
            cma_div_cell u_div (
               .clock (clock),
               .reset (reset),
               .load  (en_div[g]),
               .up    (div_q[g-1]),
               .down  (div_q[g])
            );
         end
      end
   endgenerate

   // round half away from zero, restore sign, saturate
   assign tail     = div_q[DIV_STAGES-1];
   assign round_up = ({tail.rem, 1'b0} >= {1'b0, tail.cnt});
   assign q_mag    = Q_W'(tail.quo) + Q_W'(round_up);
   always_comb begin
      if (tail.neg) begin
         avg_in = (q_mag > Q_OUT_MAX + Q_W'(1)) ? OUT_MIN : OUT_W'(Q_W'(0) - q_mag);
      end else begin
         avg_in = (q_mag > Q_OUT_MAX) ? OUT_MAX : OUT_W'(q_mag);
      end
   end

   // output register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (en_out) begin
         rsp_valid_ff <= tail.valid;
      end
      if (en_out) begin
         avg_ff  <= avg_in;
         last_ff <= tail.done;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = avg_ff;
   assign rsp_tlast  = last_ff;

endmodule

// ===== rtl/cma_checker.sv =====
`include "centered_moving_average_7_unit_assert.svh"

module cma_checker (
   input logic                      clock,
   input logic                      reset,
   input logic                      req_tvalid,
   input logic                      req_tready,
   input logic                      req_tlast,
   input logic                      rsp_tvalid,
   input logic                      rsp_tready,
   input logic [cma_pkg::OUT_W-1:0] rsp_tdata,
   input logic                      rsp_tlast
);
   import cma_pkg::*;

   // a stalled result word holds
   `CMA_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_tvalid && !rsp_tready, rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tlast))

   // after reset nothing is pending and samples are taken
   `CMA_ASSERT_NEXT(a_reset_idle, clock, 1'b0, reset, !rsp_tvalid && req_tready)

   // with no result waiting, input is blocked only by a frame flush
   `CMA_ASSERT_NOW(a_flush_only, clock, reset, !rsp_tvalid && !req_tready, $past(req_tvalid && req_tready && req_tlast) || $past(!req_tready))

endmodule

bind centered_moving_average_7_unit cma_checker u_cma_checker (.*);

// ===== sim/centered_moving_average_7_unit_tb.sv =====
`timescale 1ns / 1ps

module centered_moving_average_7_unit_tb;
   import cma_pkg::*;

   localparam int NUM_RANDOM_WORDS = 130;
   localparam int STALL_LIMIT      = 2000;
   localparam int DRAIN_CYCLES     = 20;

   localparam longint AVG_HI = (longint'(1) << (OUT_W - 1)) - 1;
   localparam longint AVG_LO = -AVG_HI - 1;

   localparam sample_type SAMPLE_MAX = {1'b0, {(SAMPLE_BITS - 1){1'b1}}};
   localparam sample_type SAMPLE_MIN = {1'b1, {(SAMPLE_BITS - 1){1'b0}}};

   typedef struct packed {
      sample_type sample;
      logic       frame_end;
   } sample_word_type;

   typedef struct packed {
      logic signed [OUT_W-1:0] average;
      logic                    frame_done;
   } average_word_type;

   logic              clock      = 1'b0;
   logic              reset      = 1'b1;
   logic              req_tvalid = 1'b0;
   logic              req_tready;
   logic [IN_W-1:0]   req_tdata  = '0;
   logic              req_tlast  = 1'b0;
   logic              rsp_tvalid;
   logic              rsp_tready = 1'b0;
   logic [OUT_W-1:0]  rsp_tdata;
   logic              rsp_tlast;

   sample_word_type  sample_words[$];
   average_word_type expected_averages[$];

   // predictor state: taps newest first, and samples seen in the frame
   sample_type tap_line[WIN_LEN];
   int         frame_seen = 0;

   int              errors = 0;
   int              burst_left = 0;
   int              gap_left = 0;
   int              stall_mode = 0;
   int              stall_phase = 0;
   int              idle_cycles = 0;
   sample_word_type next_word;

   centered_moving_average_7_unit dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast)
   );

   always #10 clock = ~clock;

   // rounded, saturated mean of taps 0..last_pos
   function automatic logic signed [OUT_W-1:0] window_average(int last_pos);
      longint          sum;
      longint unsigned mag;
      longint unsigned cnt;
      longint unsigned q;
      longint          res;
      sum = 0;
      for (int p = 0; p <= last_pos; p++)
         sum += longint'(tap_line[p]);
      cnt = longint'(last_pos + 1);
      mag = (sum < 0) ? longint'(-sum) : longint'(sum);
      mag = mag << FRAC_BITS;
      q = (2 * mag + cnt) / (2 * cnt);
      if (sum < 0) begin
         if (q > longint'(AVG_HI) + 1)
            res = AVG_LO;
         else
            res = -longint'(q);
      end else begin
         res = (q > longint'(AVG_HI)) ? AVG_HI : longint'(q);
      end
      return res[OUT_W-1:0];
   endfunction

   // shift one accepted word into the taps and queue the averages it releases
   task automatic predict_word(sample_type s, logic last);
      int m;
      int d;
      int top;
      for (int i = WIN_LEN - 1; i > 0; i--)
         tap_line[i] = tap_line[i - 1];
      tap_line[0] = s;
      m = (frame_seen + 1 > WIN_LEN) ? WIN_LEN : frame_seen + 1;
      if (!last) begin
         if (m > HALF_WIDTH) begin
            top = (2 * HALF_WIDTH > m - 1) ? m - 1 : 2 * HALF_WIDTH;
            expected_averages.push_back('{window_average(top), 1'b0});
         end
         if (frame_seen < WIN_LEN)
            frame_seen++;
      end else begin
         // flush: remaining outputs in ascending order, clipped at the last sample
         d = (m - 1 < HALF_WIDTH) ? m - 1 : HALF_WIDTH;
         while (d >= 0) begin
            top = (d + HALF_WIDTH > m - 1) ? m - 1 : d + HALF_WIDTH;
            expected_averages.push_back('{window_average(top), d == 0});
            d--;
         end
         frame_seen = 0;
      end
   endtask

   task automatic push_word(sample_type s, logic last);
      sample_words.push_back('{s, last});
   endtask

   function automatic sample_type random_sample();
      case ($urandom_range(0, 9))
         0: return SAMPLE_MAX;
         1: return SAMPLE_MIN;
         2, 3: return sample_type'(int'($urandom_range(0, 20)) - 10);
         default: return sample_type'($urandom);
      endcase
   endfunction

   // sender: bursts of words separated by random gaps
   always @(posedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
         req_tdata  <= '0;
         req_tlast  <= 1'b0;
         burst_left <= 0;
         gap_left   <= 0;
      end else begin
         if (req_tvalid && req_tready)
            predict_word(sample_type'(req_tdata), req_tlast);
         if (!req_tvalid || req_tready) begin
            if (gap_left != 0) begin
               gap_left   <= gap_left - 1;
               req_tvalid <= 1'b0;
            end else if (sample_words.size() != 0) begin
               next_word = sample_words.pop_front();
               req_tvalid <= 1'b1;
               req_tdata  <= next_word.sample;
               req_tlast  <= next_word.frame_end;
               if (burst_left <= 1) begin
                  burst_left <= $urandom_range(1, 20);
                  gap_left   <= ($urandom_range(0, 7) == 0) ? $urandom_range(4, 12)
                                                            : $urandom_range(0, 2);
               end else begin
                  burst_left <= burst_left - 1;
               end
            end else begin
               req_tvalid <= 1'b0;
            end
         end
      end
   end

   // receiver: stall pattern is redrawn whenever the phase counter wraps
   always @(posedge clock) begin
      if (stall_phase == 63) begin
         stall_phase <= 0;
         stall_mode  <= $urandom_range(0, 3);
      end else begin
         stall_phase <= stall_phase + 1;
      end
      case (stall_mode)
         0: rsp_tready <= 1'b1;
         1: rsp_tready <= $urandom_range(0, 1);
         2: rsp_tready <= ($urandom_range(0, 3) == 0);
         default: rsp_tready <= (stall_phase % 8) < 5;
      endcase
   end

   // monitor: compare each result word with the oldest expected average
   always @(posedge clock) begin
      average_word_type exp_word;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (expected_averages.size() == 0) begin
            errors++;
            $display("%0t: unexpected word: expected none, actual average %0d done %0b",
                     $time, $signed(rsp_tdata), rsp_tlast);
         end else begin
            exp_word = expected_averages.pop_front();
            if (rsp_tdata !== exp_word.average) begin
               errors++;
               $display("%0t: average mismatch: expected %0d, actual %0d",
                        $time, exp_word.average, $signed(rsp_tdata));
            end
            if (rsp_tlast !== exp_word.frame_done) begin
               errors++;
               $display("%0t: frame_done mismatch: expected %0b, actual %0b",
                        $time, exp_word.frame_done, rsp_tlast);
            end
         end
      end
   end

   // watchdog on cycles with no handshake on either side
   always @(posedge clock) begin
      if (!reset) begin
         if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready))
            idle_cycles <= 0;
         else
            idle_cycles <= idle_cycles + 1;
         if (idle_cycles >= STALL_LIMIT) begin
            $display("** centered_moving_average_7_unit: FAILED **");
            $finish;
         end
      end
   end

   initial begin
      int count;
      int len;
      for (int i = 0; i < WIN_LEN; i++)
         tap_line[i] = '0;

      // one-sample frames at both extremes
      push_word(SAMPLE_MAX, 1'b1);
      push_word(SAMPLE_MIN, 1'b1);
      // short frames, clipped at both ends
      push_word(SAMPLE_MIN, 1'b0);
      push_word(sample_type'(-1), 1'b1);
      push_word(sample_type'(1), 1'b0);
      push_word(sample_type'(-1), 1'b0);
      push_word(sample_type'(2), 1'b1);
      push_word('0, 1'b0);
      push_word(sample_type'(32'h5555_5555), 1'b0);
      push_word(sample_type'(32'hAAAA_AAAA), 1'b0);
      push_word(sample_type'(3), 1'b1);
      // full windows at the extremes, then a frame over stale taps
      for (int i = 0; i < 9; i++)
         push_word(SAMPLE_MAX, i == 8);
      for (int i = 0; i < 5; i++)
         push_word(SAMPLE_MIN, i == 4);

      repeat (11) @(posedge clock);
      reset <= 1'b0;

      // hold off until the directed part has fully drained; checked mid-cycle
      // so the sender's updates from the last edge are settled
      while (sample_words.size() != 0 || req_tvalid || expected_averages.size() != 0)
         @(negedge clock);

      // random frames, mostly short, some long
      count = 0;
      while (count < NUM_RANDOM_WORDS) begin
         len = ($urandom_range(0, 5) == 0) ? $urandom_range(8, 30) : $urandom_range(1, 9);
         for (int i = 0; i < len; i++)
            push_word(random_sample(), i == len - 1);
         count += len;
      end

      while (sample_words.size() != 0 || req_tvalid || expected_averages.size() != 0)
         @(negedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      if (errors == 0 && expected_averages.size() == 0)
         $display("** centered_moving_average_7_unit: PASSED **");
      else
         $display("** centered_moving_average_7_unit: FAILED **");
      $finish;
   end

endmodule

// ===== filelist.f =====
+incdir+rtl
rtl/cma_pkg.sv
rtl/cma_cell.sv
rtl/cma_front.sv
rtl/cma_div_cell.sv
rtl/centered_moving_average_7_unit.sv
rtl/cma_checker.sv
sim/centered_moving_average_7_unit_tb.sv
